FILE: rtl/core/iir_filter_direct_form_one_unit_assert.svh
// ----------------------------------------------------------------------------
// IIR direct form I unit - assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IIR_FILTER_DIRECT_FORM_ONE_UNIT_ASSERT_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_UNIT_ASSERT_SVH

// same-cycle implication
`define IIRDF1_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants for the IIR direct form I unit.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    // up to 7 products of 32 bits, plus sign headroom
    localparam int ACC_W     = 36;
    // quotient bits produced by the serial divider (|q| up to 2^17 - 1)
    localparam int QUO_W     = 17;
    localparam int HI_W      = ACC_W - QUO_W;
    localparam int MAX_TAPS  = 4;

    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FF0      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF1      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF2      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB1      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB2      = 3'd5;

    // a0 reset value: 1.0 in Q2.14
    localparam logic signed [COEF_W-1:0] A0_RESET = 16'sd16384;

    localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 16'sh8000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_DONE
    } div_state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic err;
    } div_stat_t;

endpackage

FILE: rtl/core/iirdf1_in_if.sv
// ----------------------------------------------------------------------------
// iirdf1_in_if
// Input sample channel: valid/ready with one signed sample per beat.
// ----------------------------------------------------------------------------
interface iirdf1_in_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);

endinterface

FILE: rtl/core/iirdf1_out_if.sv
// ----------------------------------------------------------------------------
// iirdf1_out_if
// Result channel: valid/ready with filtered sample and divide error flag.
// ----------------------------------------------------------------------------
interface iirdf1_out_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out;
    logic                                  divide_error;

    modport source (output valid, output sample_out, output divide_error, input ready);
    modport sink   (input valid, input sample_out, input divide_error, output ready);

endinterface

FILE: rtl/core/iirdf1_div.sv
// ----------------------------------------------------------------------------
// iirdf1_div
// Serial restoring divider: signed accumulator / signed a0, truncated toward
// zero and saturated to 16 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module iirdf1_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [iirdf1_pkg::ACC_W-1:0]   dividend,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]  divisor,
    output iirdf1_pkg::div_stat_t                 stat,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] quotient
);
    import iirdf1_pkg::*;

    localparam int BCNT_W = $clog2(QUO_W);

    div_state_t              state_reg;
    div_state_t              state_next;
    logic [ACC_W-1:0]        mag_reg;
    logic [QUO_W-1:0]        dvs_reg;
    logic [QUO_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [BCNT_W-1:0]       bcnt_reg;
    logic                    neg_reg;
    logic                    err_reg;
    logic [QUO_W:0]          trial;
    logic                    fits;
    logic                    ovf;

    assign trial = {rem_reg, mag_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign ovf   = (mag_reg[ACC_W-1:QUO_W] >= {{(HI_W-QUO_W){1'b0}}, dvs_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= D_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:  if (start) state_next = D_CHECK;
            D_CHECK: state_next = (err_reg || ovf) ? D_DONE : D_RUN;
            D_RUN:   if (bcnt_reg == '0) state_next = D_DONE;
            D_DONE:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (start) begin
                    mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
                    dvs_reg <= divisor[COEF_W-1] ? QUO_W'(-{divisor[COEF_W-1], divisor})
                                                 : QUO_W'({divisor[COEF_W-1], divisor});
                    neg_reg <= dividend[ACC_W-1] ^ divisor[COEF_W-1];
                    err_reg <= (divisor == '0);
                end
            end
            D_CHECK:
            begin
                // high part already >= divisor: quotient has more than 17 bits
                quo_reg  <= (err_reg || ovf) ? (err_reg ? '0 : '1) : '0;
                rem_reg  <= mag_reg[QUO_W +: QUO_W];
                bcnt_reg <= BCNT_W'(QUO_W - 1);
            end
            D_RUN:
            begin
                if (fits) begin
                    rem_reg <= QUO_W'(trial - {1'b0, dvs_reg});
                end
                else begin
                    rem_reg <= trial[QUO_W-1:0];
                end
                quo_reg  <= {quo_reg[QUO_W-2:0], fits};
                mag_reg  <= {mag_reg[ACC_W-1:QUO_W], mag_reg[QUO_W-2:0], 1'b0};
                bcnt_reg <= bcnt_reg - 1'b1;
            end
            D_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // sign and saturation on the magnitude quotient
    always_comb begin
        if (err_reg) begin
            quotient = '0;
        end
        else if (neg_reg) begin
            quotient = (quo_reg > QUO_W'(32768)) ? SAT_NEG : SAMPLE_W'(-quo_reg);
        end
        else begin
            quotient = (quo_reg > QUO_W'(32767)) ? SAT_POS : SAMPLE_W'(quo_reg);
        end
    end

    assign stat.done = (state_reg == D_DONE);
    assign stat.err  = err_reg;

endmodule

FILE: rtl/core/iir_filter_direct_form_one_unit.sv
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one_unit
// Direct form I IIR filter, 16-bit samples, Q2.14 coefficients, shared MAC
// and serial divider by a0.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------
//  din     | in  | valid / ready       | sample_in (s16)
//  dout    | out | valid / ready       | sample_out (s16), divide_error
//  cfg     | in  | cfg_we, no stall    | cfg_index (3b), cfg_data (16b)
//
//  A sample passes the MAC steps, a drain step, the divider start and the
//  divide before its result is valid, and no new beat is taken until that
//  result has left the sequencer; a zero a0 or an overflowing quotient skips
//  the 17 divider bit steps.
//  The pace is set by the single multiplier (one tap per cycle) and the
//  divider, which resolves one quotient bit per cycle.
//  din.ready is high only while idle; the next beat is taken while a result
//  still waits in the dout register. A stalled dout holds the next result
//  in the sequencer until the register frees.
//  Reset clears the histories, coefficients (a0 to 1.0) and all control.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one_unit #(
    parameter int FEEDFORWARD_TAPS = 3,
    parameter int FEEDBACK_TAPS    = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    iirdf1_in_if.sink                             din,
    iirdf1_out_if.source                          dout,
    input  logic                                  cfg_we,
    input  logic [iirdf1_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]         cfg_data
);
    import iirdf1_pkg::*;

    // MAC steps: all feedforward taps, feedback taps from 1
    localparam int NSTEP = FEEDFORWARD_TAPS + FEEDBACK_TAPS - 1;
    localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int XH    = (FEEDFORWARD_TAPS > 1) ? FEEDFORWARD_TAPS - 1 : 1;
    localparam int YH    = (FEEDBACK_TAPS > 1) ? FEEDBACK_TAPS - 1 : 1;

    state_t                       state_reg;
    state_t                       state_next;
    logic [CW-1:0]                cnt_reg;

    // coefficient file
    logic signed [COEF_W-1:0]     coef_reg [NUM_REGS];
    logic signed [COEF_W-1:0]     tap_ff [MAX_TAPS];
    logic signed [COEF_W-1:0]     tap_fb [MAX_TAPS];

    // sample histories: slot 0 is one step back
    logic signed [SAMPLE_W-1:0]   xcur_reg;
    logic signed [SAMPLE_W-1:0]   xhist_reg [XH];
    logic signed [SAMPLE_W-1:0]   yhist_reg [YH];

    // shared MAC
    logic signed [SAMPLE_W-1:0]   mul_sample;
    logic signed [COEF_W-1:0]     mul_coef;
    logic                         mul_neg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         prod_neg_reg;
    logic                         prod_vld_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      prod_ext;

    // divider
    div_stat_t                    div_stat;
    logic signed [SAMPLE_W-1:0]   div_quo;
    logic signed [SAMPLE_W-1:0]   y_reg;
    logic                         yerr_reg;

    // output register
    logic                         ovalid_reg;
    logic signed [SAMPLE_W-1:0]   osample_reg;
    logic                         oerr_reg;
    logic                         out_load;

    assign din.ready         = (state_reg == S_IDLE);
    assign dout.valid        = ovalid_reg;
    assign dout.sample_out   = osample_reg;
    assign dout.divide_error = oerr_reg;

    assign out_load = (state_reg == S_OUT) && (!ovalid_reg || dout.ready);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= (i == REG_FB_SCALE) ? A0_RESET : '0;
            end
        end
        else if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // taps past the register file read as zero
    always_comb begin
        tap_ff[0] = coef_reg[REG_FF0];
        tap_ff[1] = coef_reg[REG_FF1];
        tap_ff[2] = coef_reg[REG_FF2];
        tap_ff[3] = '0;
        tap_fb[0] = coef_reg[REG_FB_SCALE];
        tap_fb[1] = coef_reg[REG_FB1];
        tap_fb[2] = coef_reg[REG_FB2];
        tap_fb[3] = '0;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (din.valid) state_next = S_MAC;
            S_MAC:   if (cnt_reg == CW'(NSTEP - 1)) state_next = S_DRAIN;
            S_DRAIN: state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_stat.done) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg      <= '0;
            prod_vld_reg <= 1'b0;
        end
        else begin
            prod_vld_reg <= (state_reg == S_MAC);
            if (state_reg == S_IDLE) begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_MAC) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- operand select ----------------
    always_comb begin
        mul_sample = '0;
        mul_coef   = '0;
        mul_neg    = 1'b0;
        if (cnt_reg == '0) begin
            mul_sample = xcur_reg;
        end
        for (int i = 0; i < XH; i++) begin
            if (FEEDFORWARD_TAPS > 1 && cnt_reg == CW'(i + 1)) begin
                mul_sample = xhist_reg[i];
            end
        end
        for (int i = 0; i < MAX_TAPS; i++) begin
            if (i < FEEDFORWARD_TAPS && cnt_reg == CW'(i)) begin
                mul_coef = tap_ff[i];
            end
        end
        // feedback taps subtract: y[n-1-j] times a(j+1)
        for (int j = 0; j < YH; j++) begin
            if (FEEDBACK_TAPS > 1 && cnt_reg == CW'(FEEDFORWARD_TAPS + j)) begin
                mul_sample = yhist_reg[j];
                mul_coef   = tap_fb[j + 1];
                mul_neg    = 1'b1;
            end
        end
    end

    // ---------------- MAC datapath ----------------
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk) begin
        prod_reg     <= mul_sample * mul_coef;
        prod_neg_reg <= mul_neg;
        if (state_reg == S_IDLE) begin
            acc_reg <= '0;
            if (din.valid) begin
                xcur_reg <= din.sample_in;
            end
        end
        else if (prod_vld_reg) begin
            acc_reg <= prod_neg_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
        if (state_reg == S_DIV && div_stat.done) begin
            y_reg    <= div_quo;
            yerr_reg <= div_stat.err;
        end
    end

    iirdf1_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend (acc_reg),
        .divisor  (coef_reg[REG_FB_SCALE]),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // ---------------- histories ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < XH; i++) begin
                xhist_reg[i] <= '0;
            end
            for (int i = 0; i < YH; i++) begin
                yhist_reg[i] <= '0;
            end
        end
        else if (out_load) begin
            if (FEEDFORWARD_TAPS > 1) begin
                for (int i = XH - 1; i > 0; i--) begin
                    xhist_reg[i] <= xhist_reg[i - 1];
                end
                xhist_reg[0] <= xcur_reg;
            end
            if (FEEDBACK_TAPS > 1) begin
                for (int i = YH - 1; i > 0; i--) begin
                    yhist_reg[i] <= yhist_reg[i - 1];
                end
                yhist_reg[0] <= y_reg;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load) begin
            ovalid_reg <= 1'b1;
        end
        else if (dout.ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            osample_reg <= y_reg;
            oerr_reg    <= yerr_reg;
        end
    end

endmodule

FILE: rtl/core/iirdf1_checker.sv
// ----------------------------------------------------------------------------
// iirdf1_checker
// Port-level checks for the IIR direct form I unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "iir_filter_direct_form_one_unit_assert.svh"

module iirdf1_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out,
    input logic                                  divide_error
);

    // one sample in flight: ready drops after a beat is taken
    `IIRDF1_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // a result never rises in the cycle after a beat is taken
    `IIRDF1_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "early result")

    // zero divisor forces a zero sample
    `IIRDF1_ASSERT_NOW(a_err_zero, out_valid && divide_error, sample_out == '0, "error not zero")

    // stalled result holds
    `IIRDF1_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out), "out dropped")

endmodule

bind iir_filter_direct_form_one_unit iirdf1_checker u_iirdf1_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (din.valid),
    .in_ready     (din.ready),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .sample_out   (dout.sample_out),
    .divide_error (dout.divide_error)
);

FILE: tb/sv/iir_filter_direct_form_one_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one_unit_test
// Self-checking bench for the direct form I IIR unit. A local model of the
// filter tracks the coefficients and both histories. It predicts sample_out
// and divide_error for every input beat. The bench compares each result beat
// in order, while the input and result channels idle and stall at random.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one_unit_test;

    import iirdf1_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1400;
    // comfortably above the accept-to-result latency of the block
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_CAP    = 40;

    // indexes past the last register; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ZERO = 16'sd0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       div_err;
    } filt_out_t;

    // flavors of coefficient sets used by the random phases
    typedef enum logic [1:0] {
        MIX_FULL,
        MIX_EXTREME,
        MIX_DAMPED,
        MIX_TINY_A0
    } coef_mix_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    iirdf1_in_if  din_bus ();
    iirdf1_out_if dout_bus ();

    iir_filter_direct_form_one_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_bus),
        .dout      (dout_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Filter model state: coefficient file plus x[n-1], x[n-2], y[n-1], y[n-2]
    // ------------------------------------------------------------------------
    logic signed [COEF_W-1:0]   coef [NUM_REGS];
    logic signed [SAMPLE_W-1:0] x_d1 = '0;
    logic signed [SAMPLE_W-1:0] x_d2 = '0;
    logic signed [SAMPLE_W-1:0] y_d1 = '0;
    logic signed [SAMPLE_W-1:0] y_d2 = '0;

    // predicted results, oldest first
    filt_out_t y_predicted [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of one filter step. Products are exact, the numerator is Q.14,
    // division by a0 truncates toward zero and the quotient saturates to 16
    // bits. A zero a0 gives 0 plus the error flag, and 0 goes into the output
    // history. The input history shifts in every case.
    // ------------------------------------------------------------------------
    function automatic void filter_predict(input logic signed [SAMPLE_W-1:0] x);
        longint    acc;
        longint    quo;
        filt_out_t res;
        acc = longint'(x)    * longint'(coef[REG_FF0])
            + longint'(x_d1) * longint'(coef[REG_FF1])
            + longint'(x_d2) * longint'(coef[REG_FF2])
            - longint'(y_d1) * longint'(coef[REG_FB1])
            - longint'(y_d2) * longint'(coef[REG_FB2]);
        if (coef[REG_FB_SCALE] == COEF_ZERO)
        begin
            res.sample  = '0;
            res.div_err = 1'b1;
        end
        else
        begin
            quo = acc / longint'(coef[REG_FB_SCALE]);
            if (quo > longint'(SAT_POS))
                quo = longint'(SAT_POS);
            else if (quo < longint'(SAT_NEG))
                quo = longint'(SAT_NEG);
            res.sample  = SAMPLE_W'(quo);
            res.div_err = 1'b0;
        end
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = res.sample;
        y_predicted.push_back(res);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input logic signed [SAMPLE_W-1:0] got_sample,
                                input logic                       got_err);
        filt_out_t want;
        if (y_predicted.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat sample_out=%0d divide_error=%0b",
                                      got_sample, got_err));
            return;
        end
        want = y_predicted.pop_front();
        if (got_sample !== want.sample)
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      got_sample, want.sample));
        if (got_err !== want.div_err)
            report_mismatch($sformatf("divide_error %0b, predicted %0b",
                                      got_err, want.div_err));
    endtask

    // ------------------------------------------------------------------------
    // Input side. Beats go out in bursts; before each burst the valid line
    // may drop for a random gap, so gaps land on every phase of the block's
    // MAC/divide sequence. Within a burst valid stays high from beat to beat.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                din_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        din_bus.valid     <= 1'b1;
        din_bus.sample_in <= x;
        do
            @(posedge clk);
        while (din_bus.ready !== 1'b1);
        filter_predict(x);
    endtask

    // Drop valid and let every pending result drain before touching config.
    task automatic wait_idle();
        din_bus.valid <= 1'b0;
        burst_left = 0;
        while (y_predicted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write per clock; cfg_we is left high for back-to-back use.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0]    val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < NUM_REGS)
            coef[idx] = val;
    endtask

    task automatic load_filter(input logic signed [COEF_W-1:0] b0, b1, b2,
                               input logic signed [COEF_W-1:0] a0, a1, a2);
        wait_idle();
        write_reg(REG_FF0, b0);
        write_reg(REG_FF1, b1);
        write_reg(REG_FF2, b2);
        write_reg(REG_FB_SCALE, a0);
        write_reg(REG_FB1, a1);
        write_reg(REG_FB2, a2);
        cfg_we <= 1'b0;
    endtask

    // Samples: extremes, small values near zero, and the full range.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SAT_POS;
            1:       return SAT_NEG;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_for(input coef_mix_t mix,
                                                          input logic [REG_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] pick;
        case (mix)
            MIX_EXTREME:
            begin
                case ($urandom_range(0, 6))
                    0:       pick = SAT_NEG;
                    1:       pick = SAT_POS;
                    2:       pick = COEF_ZERO;
                    3:       pick = 16'sd1;
                    4:       pick = -16'sd1;
                    5:       pick = -A0_RESET;
                    default: pick = A0_RESET;
                endcase
            end
            MIX_DAMPED:
            begin
                // a0 = 1.0, modest feedback: outputs ring but mostly stay in range
                if (idx == REG_FB_SCALE)
                    pick = A0_RESET;
                else if (idx == REG_FB1)
                    pick = COEF_W'(int'($urandom_range(0, 24000)) - 12000);
                else if (idx == REG_FB2)
                    pick = COEF_W'($urandom_range(0, 8000));
                else
                    pick = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
            end
            MIX_TINY_A0:
            begin
                // tiny divisor drives the quotient far past 16 bits
                if (idx == REG_FB_SCALE)
                    pick = ($urandom_range(0, 1) == 0) ? COEF_W'($urandom_range(1, 8))
                                                       : -COEF_W'($urandom_range(1, 8));
                else
                    pick = COEF_W'($urandom);
            end
            default:
                pick = COEF_W'($urandom);
        endcase
        return pick;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: a stall pattern of its own. Alternating ready/stall runs
    // of random length, broken now and then by a long stretch of ready.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int   run_left;
        int   calm_left;
        logic rdy;
        run_left  = 0;
        calm_left = 0;
        rdy       = 1'b0;
        dout_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && dout_bus.valid === 1'b1 && dout_bus.ready === 1'b1)
                check_result(dout_bus.sample_out, dout_bus.divide_error);
            if (calm_left > 0)
            begin
                calm_left--;
                rdy = 1'b1;
            end
            else if (run_left > 0)
                run_left--;
            else if ($urandom_range(0, 15) == 0)
            begin
                calm_left = $urandom_range(50, 300);
                rdy       = 1'b1;
            end
            else
            begin
                rdy      = !rdy;
                run_left = rdy ? $urandom_range(0, 20) : $urandom_range(0, 15);
            end
            dout_bus.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All b_k are zero out of reset, so every output is zero.
    task automatic test_reset_coefs();
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
    endtask

    // b0 = a0 = 1.0: the output follows the input exactly.
    task automatic test_passthrough();
        load_filter(A0_RESET, COEF_ZERO, COEF_ZERO, A0_RESET, COEF_ZERO, COEF_ZERO);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
    endtask

    // Quotient out of range both ways, then a negative a0 with full feedback.
    task automatic test_saturation();
        load_filter(SAT_POS, SAT_POS, SAT_POS, 16'sd1, COEF_ZERO, COEF_ZERO);
        send_sample(SAT_POS);
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
        send_sample(SAT_NEG);
        send_sample(SAT_NEG);
        load_filter(SAT_NEG, COEF_ZERO, COEF_ZERO, SAT_NEG, SAT_NEG, SAT_POS);
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
        send_sample(16'sd1);
    endtask

    // a0 = 0 flags the error and stores zero as y[n]; once a0 is back the
    // zeroed output history and the still-shifted input history show through.
    task automatic test_zero_divisor();
        load_filter(A0_RESET, A0_RESET, COEF_ZERO, COEF_ZERO, A0_RESET, COEF_ZERO);
        send_sample(16'sd100);
        send_sample(-16'sd200);
        send_sample(SAT_POS);
        load_filter(A0_RESET, A0_RESET, A0_RESET, A0_RESET, A0_RESET, A0_RESET);
        send_sample(16'sd7);
        send_sample(-16'sd3);
    endtask

    // Writes to indexes past the register file must not alias onto one.
    task automatic test_spare_index();
        load_filter(16'sd4096, -16'sd2048, 16'sd1024, 16'sd8192, -16'sd3000, 16'sd1500);
        @(posedge clk);
        write_reg(REG_SPARE_LO, '0);
        write_reg(REG_SPARE_HI, '0);
        cfg_we <= 1'b0;
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        send_sample(SAT_POS);
    endtask

    // Phases of random coefficient sets, each followed by random samples.
    task automatic test_random_phases();
        int        sent;
        int        phase_len;
        coef_mix_t mix;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix = coef_mix_t'($urandom_range(0, 3));
            load_filter(coef_for(mix, REG_FF0), coef_for(mix, REG_FF1),
                        coef_for(mix, REG_FF2), coef_for(mix, REG_FB_SCALE),
                        coef_for(mix, REG_FB1), coef_for(mix, REG_FB2));
            phase_len = $urandom_range(30, 90);
            repeat (phase_len)
            begin
                send_sample(rand_sample());
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        for (int k = 0; k < NUM_REGS; k++)
            coef[k] = COEF_ZERO;
        coef[REG_FB_SCALE] = A0_RESET;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        din_bus.valid     <= 1'b0;
        din_bus.sample_in <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_passthrough();
        test_saturation();
        test_zero_divisor();
        test_spare_index();
        test_random_phases();

        // drain the last results, then give the block time to misbehave
        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/iirdf1_pkg.sv
rtl/core/iirdf1_in_if.sv
rtl/core/iirdf1_out_if.sv
rtl/core/iirdf1_div.sv
rtl/core/iir_filter_direct_form_one_unit.sv
rtl/core/iirdf1_checker.sv
tb/sv/iir_filter_direct_form_one_unit_test.sv
